@@ rtl/atr_pkg.sv @@
package atr_pkg;

    // Command codes carried by a request item.
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Layer kinds.
    localparam logic [1:0] LAYER_PARALLAX   = 2'd0;
    localparam logic [1:0] LAYER_BACKGROUND = 2'd1;
    localparam logic [1:0] LAYER_FOREGROUND = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_KIND        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANIMATION_PRESENT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOLD_DISABLE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARALLAX_PRESENT  = 2'd3;

    // Fixed field widths and constants.
    localparam int          STEP_FIELD_W = 32;
    localparam int          STEP_SHIFT   = 3;
    localparam int          STEP_Q_MAX_W = STEP_FIELD_W - STEP_SHIFT;
    localparam int          DIVIDEND_W   = 32;
    localparam int          DIV_BITS     = 4;
    localparam logic [7:0]  EMPTY_TILE   = 8'hff;
    localparam logic [3:0]  FOLD_MIN     = 4'd9;
    localparam logic [3:0]  FOLD_MAX     = 4'd14;
    localparam logic [3:0]  FOLD_OFFSET  = 4'd8;
    localparam int          MID_DEPTH    = 4;
    localparam int          OUT_DEPTH    = 2;

    // Input item.
    typedef struct packed {
        logic                    command;
        logic [7:0]              tile_code;
        logic [7:0]              attribute_byte;
        logic [STEP_FIELD_W-1:0] frame_step;
        logic [7:0]              entry_start;
        logic [7:0]              entry_length;
    } request_t;

    // Result item.
    typedef struct packed {
        logic [7:0] shown_tile;
        logic       from_animated_set;
        logic       draw_enable;
        logic       draw_transparent;
    } result_t;

    // Configuration register set.
    typedef struct packed {
        logic [1:0] layer_kind;
        logic       animation_present;
        logic       fold_disable;
        logic       parallax_present;
    } cfg_t;

    // Classified operation passed from the front to the back.
    typedef struct packed {
        logic                    is_write;
        logic                    in_range;
        logic [7:0]              tile_code;
        logic [7:0]              entry_start;
        logic [7:0]              entry_length;
        logic [STEP_Q_MAX_W-1:0] step_q;
        logic                    anim_req;
        logic                    reverse;
        logic                    transparent;
    } op_t;

    // One stage of the remainder pipeline.
    typedef struct packed {
        logic [7:0]            tile;
        logic [7:0]            start;
        logic [7:0]            len;
        logic [7:0]            rem;
        logic [DIVIDEND_W-1:0] dividend;
        logic                  anim;
        logic                  reverse;
        logic                  transparent;
    } stage_t;

endpackage

@@ rtl/atr_queue.sv @@
module atr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for waiting items.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/atr_front.sv @@
module atr_front #(
    parameter int LOOP_ENTRIES = 256,
    parameter int STEP_WIDTH   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  atr_pkg::request_t request,
    input  atr_pkg::cfg_t     cfg,
    output logic              q_push,
    output atr_pkg::op_t      q_op,
    input  logic              q_full
);

    import atr_pkg::*;

    logic       front_valid_reg;
    op_t        front_op_reg;
    op_t        op_next;
    logic       advance;
    logic [3:0] code_raw;
    logic [3:0] code;
    logic [3:0] fwd_code;
    logic [3:0] rev_code;
    logic       match_fwd;
    logic       match_rev;
    logic       layer_ok;

    // The holding register moves on whenever it is empty or the queue takes it.
    assign advance = !front_valid_reg || !q_full;
    assign full    = !advance;
    assign q_push  = front_valid_reg && !q_full;
    assign q_op    = front_op_reg;

    // Classify the incoming item: fold the animation code and match it to the layer.
    always_comb
    begin
        code_raw = request.attribute_byte[7:4];
        code     = code_raw;
        if (!cfg.fold_disable && (code_raw >= FOLD_MIN) && (code_raw <= FOLD_MAX))
        begin
            code = code_raw - FOLD_OFFSET;
        end
        fwd_code  = {1'b0, cfg.layer_kind, 1'b1};
        rev_code  = fwd_code + 4'd1;
        match_fwd = (code == fwd_code);
        match_rev = (code == rev_code);
        layer_ok  = (cfg.layer_kind <= LAYER_FOREGROUND);

        op_next.is_write     = (request.command == CMD_WRITE);
        op_next.in_range     = ({1'b0, request.tile_code} < 9'(LOOP_ENTRIES));
        op_next.tile_code    = request.tile_code;
        op_next.entry_start  = request.entry_start;
        op_next.entry_length = request.entry_length;
        op_next.step_q       = STEP_Q_MAX_W'(request.frame_step[STEP_WIDTH-1:STEP_SHIFT]);
        op_next.anim_req     = cfg.animation_present && layer_ok && (match_fwd || match_rev);
        op_next.reverse      = match_rev;

        case (cfg.layer_kind)
            LAYER_PARALLAX:   op_next.transparent = 1'b0;
            LAYER_BACKGROUND: op_next.transparent = cfg.parallax_present;
            default:          op_next.transparent = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            front_op_reg <= op_next;
        end
    end

endmodule

@@ rtl/atr_back.sv @@
module atr_back #(
    parameter int LOOP_ENTRIES = 256,
    parameter int STEP_WIDTH   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    output logic              q_pop,
    input  atr_pkg::op_t      q_op,
    input  logic              out_full,
    output logic              out_push,
    output atr_pkg::result_t  out_result
);

    import atr_pkg::*;

    localparam int IDX_W = $clog2(LOOP_ENTRIES);
    localparam int Q_W   = STEP_WIDTH - STEP_SHIFT;
    localparam int NS    = (Q_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W = NS * DIV_BITS;

    logic [15:0]             loop_mem [LOOP_ENTRIES];
    logic [LOOP_ENTRIES-1:0] entry_valid_reg;
    logic [IDX_W-1:0]        idx;
    logic                    wr_en;
    logic                    advance;

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [15:0] rd_data_reg;
    logic        rd_hit_reg;

    stage_t          stage_in  [NS];
    stage_t          stage_out [NS];
    stage_t          st_reg    [NS];
    logic [NS-1:0]   vld_reg;

    stage_t     last;
    logic [7:0] tile_fwd;
    logic [7:0] tile_rev;
    logic [7:0] tile_final;

    // The whole back pipeline stalls only when its last stage cannot hand off.
    assign advance = !(vld_reg[NS-1] && out_full);
    assign q_pop   = advance && !q_empty;
    assign idx     = q_op.tile_code[IDX_W-1:0];
    assign wr_en   = q_pop && q_op.is_write && q_op.in_range;

    // Loop table: start in the upper byte, length in the lower byte.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            loop_mem[idx] <= {q_op.entry_start, q_op.entry_length};
        end
        if (q_pop)
        begin
            rd_data_reg <= loop_mem[idx];
            rd_hit_reg  <= entry_valid_reg[idx] && q_op.in_range;
            s1_op_reg   <= q_op;
        end
    end

    // Entries that were never written read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[idx] <= 1'b1;
            end
            if (advance)
            begin
                s1_valid_reg <= q_pop && !q_op.is_write;
            end
        end
    end

    // Entry to the remainder pipeline.
    always_comb
    begin
        stage_in[0].tile        = s1_op_reg.tile_code;
        stage_in[0].start       = rd_hit_reg ? rd_data_reg[15:8] : 8'd0;
        stage_in[0].len         = rd_hit_reg ? rd_data_reg[7:0] : 8'd0;
        stage_in[0].rem         = 8'd0;
        stage_in[0].dividend    = DIVIDEND_W'(s1_op_reg.step_q);
        stage_in[0].anim        = s1_op_reg.anim_req && (stage_in[0].len != 8'd0);
        stage_in[0].reverse     = s1_op_reg.reverse;
        stage_in[0].transparent = s1_op_reg.transparent;
    end

    // Restoring remainder, DIV_BITS dividend bits per stage, most significant first.
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        if (k > 0)
        begin : g_link
            assign stage_in[k] = st_reg[k-1];
        end

        always_comb
        begin
            stage_t     st;
            logic [8:0] r9;
            st = stage_in[k];
            r9 = '0;
            for (int b = 0; b < DIV_BITS; b++)
            begin
                r9 = {st.rem, st.dividend[PAD_W-1]};
                if (r9 >= {1'b0, st.len})
                begin
                    r9 = r9 - {1'b0, st.len};
                end
                st.rem      = r9[7:0];
                st.dividend = st.dividend << 1;
            end
            stage_out[k] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k] <= (k == 0) ? s1_valid_reg : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[k] <= stage_out[k];
            end
        end
    end

    // Final tile selection from the phase.
    always_comb
    begin
        last       = st_reg[NS-1];
        tile_fwd   = last.start + last.rem;
        tile_rev   = last.start + (last.len - 8'd1 - last.rem);
        tile_final = last.tile;
        if (last.anim)
        begin
            tile_final = last.reverse ? tile_rev : tile_fwd;
        end
        out_result.shown_tile        = tile_final;
        out_result.from_animated_set = last.anim;
        out_result.draw_enable       = (tile_final != EMPTY_TILE);
        out_result.draw_transparent  = last.transparent;
    end

    assign out_push = vld_reg[NS-1] && !out_full;

`ifndef SYNTHESIS
    a_s1_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg) |=> vld_reg[0])
        else $error("resolve item lost between table read and remainder pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && out_full) |=> ($stable(st_reg[NS-1]) && vld_reg[NS-1]))
        else $error("last stage changed while stalled");

    a_no_write_in_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !s1_op_reg.is_write)
        else $error("write item entered the resolve pipeline");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> entry_valid_reg[$past(idx)])
        else $error("written table entry not marked valid");
`endif

endmodule

@@ rtl/animated_tile_resolver.sv @@
// Path: a resolve item passes through the front holding register, the middle queue,
// the loop table read, the remainder pipeline of 4 bits per stage and the result queue.
// Throughput: one item per cycle, writes and resolves alike, while full is low; writes give no result.
// Reset: asynchronous and active low; it empties the queues and pipeline, marks every
// loop table entry invalid (reads as zero) at once and restores the register defaults.
module animated_tile_resolver #(
    parameter int LOOP_ENTRIES = 256,
    parameter int STEP_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  atr_pkg::request_t                     request,
    output logic                                  empty,
    input  logic                                  pop,
    output atr_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [atr_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [atr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import atr_pkg::*;

    cfg_t                   cfg_reg;
    logic                   mid_push;
    op_t                    mid_in;
    logic                   mid_full;
    logic                   mid_pop;
    logic [$bits(op_t)-1:0] mid_out;
    logic                   mid_empty;
    logic                   res_push;
    result_t                res_in;
    logic                   res_full;
    logic [$bits(result_t)-1:0] res_out;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_kind        <= LAYER_BACKGROUND;
            cfg_reg.animation_present <= 1'b0;
            cfg_reg.fold_disable      <= 1'b0;
            cfg_reg.parallax_present  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LAYER_KIND:        cfg_reg.layer_kind        <= cfg_data;
                CFG_ANIMATION_PRESENT: cfg_reg.animation_present <= cfg_data[0];
                CFG_FOLD_DISABLE:      cfg_reg.fold_disable      <= cfg_data[0];
                CFG_PARALLAX_PRESENT:  cfg_reg.parallax_present  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: accept and classify.
    atr_front #(
        .LOOP_ENTRIES (LOOP_ENTRIES),
        .STEP_WIDTH   (STEP_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .cfg     (cfg_reg),
        .q_push  (mid_push),
        .q_op    (mid_in),
        .q_full  (mid_full)
    );

    // Queue between front and back.
    atr_queue #(
        .W     ($bits(op_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty)
    );

    // Back: table access, phase and tile selection.
    atr_back #(
        .LOOP_ENTRIES (LOOP_ENTRIES),
        .STEP_WIDTH   (STEP_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (mid_empty),
        .q_pop      (mid_pop),
        .q_op       (op_t'(mid_out)),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_result (res_in)
    );

    // Result queue seen by the consumer.
    atr_queue #(
        .W     ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_out),
        .empty     (empty)
    );

    assign result = result_t'(res_out);

endmodule

@@ tb/tb_animated_tile_resolver.sv @@
`timescale 1ns / 100ps

module tb_animated_tile_resolver;
    import atr_pkg::*;

    // Layer kind 3 is legal in the register but selects no layer.
    localparam logic [1:0] LAYER_UNUSED = 2'd3;
    // This covers writes still in flight along the deepest path.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PER_PHASE = 105;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    request_t   request;
    logic       empty;
    logic       pop;
    result_t    result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the loop table and the configuration registers.
    logic [7:0] loop_start_mem [256];
    logic [7:0] loop_len_mem [256];
    logic [1:0] cur_layer;
    logic       cur_anim_present;
    logic       cur_room_off;
    logic       cur_parallax;

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      tx_idle_pct = 16;
    int      rx_idle_pct = 68;

    animated_tile_resolver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The result side pops at random according to the current idle rate.
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Works out the tile that a resolve item should show under the current settings.
    function automatic result_t resolve_tile(request_t r);
        result_t    res;
        logic [3:0] code;
        logic [3:0] fwd_code;
        logic [7:0] len;
        logic [7:0] start;
        logic [31:0] quot;
        logic [7:0] phase;
        logic [7:0] tile;
        tile = r.tile_code;
        res.from_animated_set = 1'b0;
        case (cur_layer)
            LAYER_PARALLAX:   res.draw_transparent = 1'b0;
            LAYER_BACKGROUND: res.draw_transparent = cur_parallax;
            default:          res.draw_transparent = 1'b1;
        endcase
        if (cur_anim_present && cur_layer != LAYER_UNUSED)
        begin
            fwd_code = {1'b0, cur_layer, 1'b1};
            code = r.attribute_byte[7:4];
            if (!cur_room_off && code >= FOLD_MIN && code <= FOLD_MAX)
                code = code - FOLD_OFFSET;
            len = loop_len_mem[r.tile_code];
            start = loop_start_mem[r.tile_code];
            if ((code == fwd_code || code == fwd_code + 4'd1) && len != 8'd0)
            begin
                quot = r.frame_step >> STEP_SHIFT;
                phase = 8'(quot % {24'd0, len});
                if (code == fwd_code)
                    tile = start + phase;
                else
                    tile = start + (len - 8'd1 - phase);
                res.from_animated_set = 1'b1;
            end
        end
        res.shown_tile = tile;
        res.draw_enable = (tile != 8'hff);
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
            error_count++;
        end
    endtask

    // Tracks every accepted item and checks every accepted result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (request.command == CMD_WRITE)
                begin
                    loop_start_mem[request.tile_code] = request.entry_start;
                    loop_len_mem[request.tile_code] = request.entry_length;
                end
                else
                    pending_results.push_back(resolve_tile(request));
            end
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %h", $realtime, result);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("shown_tile", want.shown_tile, result.shown_tile);
                    check_field("from_animated_set", 8'(want.from_animated_set),
                                8'(result.from_animated_set));
                    check_field("draw_enable", 8'(want.draw_enable), 8'(result.draw_enable));
                    check_field("draw_transparent", 8'(want.draw_transparent),
                                8'(result.draw_transparent));
                end
            end
        end
    end

    // Sends one item, idling first at the current rate, and waits until it is taken.
    task automatic send_item(request_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] start, logic [7:0] len);
        request_t r;
        r.command = CMD_WRITE;
        r.tile_code = idx;
        r.attribute_byte = 8'($urandom);
        r.frame_step = $urandom;
        r.entry_start = start;
        r.entry_length = len;
        send_item(r);
    endtask

    task automatic resolve(logic [7:0] tile, logic [7:0] attr, logic [31:0] step);
        request_t r;
        r.command = CMD_RESOLVE;
        r.tile_code = tile;
        r.attribute_byte = attr;
        r.frame_step = step;
        r.entry_start = 8'($urandom);
        r.entry_length = 8'($urandom);
        send_item(r);
    endtask

    // Waits until every result has come and the pipeline has emptied.
    // The first edge lets the tracker record the item taken at the last edge.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LAYER_KIND:        cur_layer = data;
            CFG_ANIMATION_PRESENT: cur_anim_present = data[0];
            CFG_FOLD_DISABLE:      cur_room_off = data[0];
            default:               cur_parallax = data[0];
        endcase
    endtask

    // Writes all four registers; the spare data bit of the flags is random.
    task automatic set_config(logic [1:0] layer, logic anim, logic room, logic parallax);
        wait_idle();
        cfg_put(CFG_LAYER_KIND, layer);
        cfg_put(CFG_ANIMATION_PRESENT, {1'($urandom), anim});
        cfg_put(CFG_FOLD_DISABLE, {1'($urandom), room});
        cfg_put(CFG_PARALLAX_PRESENT, {1'($urandom), parallax});
        cfg_valid <= 1'b0;
    endtask

    // Reset defaults: no animation table, so tiles pass unchanged.
    task automatic test_pass_through();
        load_entry(8'd5, 8'd100, 8'd4);
        resolve(8'd5, 8'h30, 32'd0);
        resolve(8'h00, 8'h00, 32'd0);
        resolve(8'hff, 8'hff, 32'hffff_ffff);
    endtask

    // Forward and reverse loops, folding, wrap of the sum and zero length.
    task automatic test_loop_phases();
        set_config(LAYER_BACKGROUND, 1'b1, 1'b0, 1'b1);
        load_entry(8'd255, 8'd250, 8'd10);
        load_entry(8'd0, 8'd255, 8'd255);
        load_entry(8'd7, 8'd0, 8'd1);
        load_entry(8'd9, 8'd60, 8'd0);
        resolve(8'd5, 8'h30, 32'd0);
        resolve(8'd5, 8'h3f, 32'd40);
        resolve(8'd5, 8'h40, 32'd40);
        resolve(8'd5, 8'hb1, 32'd16);
        resolve(8'd5, 8'hc2, 32'd16);
        // Start plus phase runs past 255 and wraps.
        resolve(8'd255, 8'h30, 32'd72);
        // Lands exactly on the empty tile.
        resolve(8'd255, 8'h30, 32'd40);
        resolve(8'd0, 8'h3c, 32'hffff_ffff);
        resolve(8'd0, 8'h4c, 32'hffff_fff8);
        resolve(8'd7, 8'h40, 32'h1234_5678);
        resolve(8'd9, 8'h30, 32'd8);
        // Codes 15 and 8 sit just outside the folded range.
        resolve(8'd5, 8'hf0, 32'd8);
        resolve(8'd5, 8'h80, 32'd8);
    endtask

    // With the room deactivated, codes 9 to 14 are taken as they are.
    task automatic test_room_fold();
        set_config(LAYER_BACKGROUND, 1'b1, 1'b1, 1'b0);
        resolve(8'd5, 8'hb0, 32'd0);
        resolve(8'd5, 8'h30, 32'd8);
    endtask

    // Each layer kind, the unused one included, with its own code pair.
    task automatic test_layer_kinds();
        logic [1:0] kinds [4] = '{LAYER_PARALLAX, LAYER_BACKGROUND,
                                  LAYER_FOREGROUND, LAYER_UNUSED};
        logic [3:0] fwd;
        for (int k = 0; k < 4; k++)
        begin
            set_config(kinds[k], 1'b1, 1'b0, 1'($urandom));
            fwd = {1'b0, kinds[k], 1'b1};
            resolve(8'd5, {fwd, 4'h5}, 32'd24);
            resolve(8'd5, {fwd + 4'd9, 4'ha}, 32'd24);
        end
    endtask

    // Mostly resolves with some table loads, on a small pool of tiles, mostly with the layer's codes.
    task automatic test_random_traffic();
        logic [1:0] kinds [4] = '{LAYER_PARALLAX, LAYER_BACKGROUND,
                                  LAYER_FOREGROUND, LAYER_UNUSED};
        int         tx_modes [3] = '{16, 68, 0};
        int         rx_modes [3] = '{68, 16, 0};
        request_t   r;
        logic [3:0] fwd;
        logic [3:0] code;
        for (int m = 0; m < 3; m++)
        begin
            for (int ph = 0; ph < 4; ph++)
            begin
                set_config(kinds[ph], !(m == 2 && ph == 1), 1'($urandom), 1'($urandom));
                tx_idle_pct = tx_modes[m];
                rx_idle_pct = rx_modes[m];
                fwd = {1'b0, cur_layer, 1'b1};
                for (int n = 0; n < RANDOM_PER_PHASE; n++)
                begin
                    r.command = ($urandom_range(99) < 20) ? CMD_WRITE : CMD_RESOLVE;
                    r.tile_code = ($urandom_range(3) != 0) ? 8'($urandom_range(15))
                                                           : 8'($urandom);
                    case ($urandom_range(5))
                        0:       code = fwd;
                        1:       code = fwd + 4'd1;
                        2:       code = fwd + 4'd8;
                        3:       code = fwd + 4'd9;
                        default: code = 4'($urandom);
                    endcase
                    r.attribute_byte = {code, 4'($urandom)};
                    r.frame_step = ($urandom_range(3) == 0) ? 32'($urandom_range(255))
                                                            : 32'($urandom);
                    r.entry_start = 8'($urandom);
                    case ($urandom_range(7))
                        0:       r.entry_length = 8'd0;
                        1:       r.entry_length = 8'd255;
                        2:       r.entry_length = 8'($urandom);
                        default: r.entry_length = 8'($urandom_range(12, 1));
                    endcase
                    send_item(r);
                end
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 256; i++)
        begin
            loop_start_mem[i] = 8'd0;
            loop_len_mem[i] = 8'd0;
        end
        cur_layer = LAYER_BACKGROUND;
        cur_anim_present = 1'b0;
        cur_room_off = 1'b0;
        cur_parallax = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pass_through();
        test_loop_phases();
        test_room_fold();
        test_layer_kinds();
        test_random_traffic();
        wait_idle();

        if (error_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/atr_pkg.sv
rtl/atr_queue.sv
rtl/atr_front.sv
rtl/atr_back.sv
rtl/animated_tile_resolver.sv
tb/tb_animated_tile_resolver.sv
